// File: design/slm_pkg.sv
`timescale 1ns / 1ps

package slm_pkg;

    // Element width of both lists and of the merged output
    localparam int unsigned ELEM_W = 32;

    // Item kind codes
    localparam logic [1:0] KIND_PUSH_A = 2'd0;
    localparam logic [1:0] KIND_PUSH_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // Input transfer payload
    typedef struct packed {
        logic [1:0]               kind;
        logic signed [ELEM_W-1:0] value;
    } slm_in_t;

    // Output transfer payload
    typedef struct packed {
        logic signed [ELEM_W-1:0] merged_value;
        logic                     last;
        logic                     overflow;
    } slm_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

// File: design/slm_list_mem.sv
`timescale 1ns / 1ps

module slm_list_mem #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [slm_pkg::ELEM_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [slm_pkg::ELEM_W-1:0] rd_data
);

    logic signed [slm_pkg::ELEM_W-1:0] mem [DEPTH];
    logic signed [slm_pkg::ELEM_W-1:0] rd_data_reg;

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/slm_seq.sv
`timescale 1ns / 1ps

module slm_seq #(
    parameter int unsigned DEPTH   = 32,
    parameter int unsigned ADDR_W  = 5,
    parameter int unsigned COUNT_W = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  slm_pkg::slm_in_t                  s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output slm_pkg::slm_out_t                 m_data,
    // list A memory
    output logic                              a_we,
    output logic [ADDR_W-1:0]                 a_waddr,
    output logic [ADDR_W-1:0]                 a_raddr,
    input  logic signed [slm_pkg::ELEM_W-1:0] a_rdata,
    // list B memory
    output logic                              b_we,
    output logic [ADDR_W-1:0]                 b_waddr,
    output logic [ADDR_W-1:0]                 b_raddr,
    input  logic signed [slm_pkg::ELEM_W-1:0] b_rdata
);

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] ONE_C   = COUNT_W'(1);

    slm_pkg::state_t   state_reg, state_next;
    logic [COUNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [COUNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic [COUNT_W-1:0] ptr_a_reg, ptr_a_next;
    logic [COUNT_W-1:0] ptr_b_reg, ptr_b_next;
    logic               drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    slm_pkg::slm_out_t  out_data_reg, out_data_next;

    logic in_xfer;
    logic out_free;
    logic is_push_a;
    logic is_push_b;
    logic is_run;
    logic lists_empty;
    logic a_avail;
    logic b_avail;
    logic take_a;
    logic [COUNT_W-1:0] ptr_a_adv;
    logic [COUNT_W-1:0] ptr_b_adv;
    logic done;

    // Handshake and decode
    assign s_ready     = (state_reg == slm_pkg::ST_IDLE);
    assign in_xfer     = s_valid && s_ready;
    assign out_free    = !out_valid_reg || m_ready;
    assign is_push_a   = (s_data.kind == slm_pkg::KIND_PUSH_A);
    assign is_push_b   = (s_data.kind == slm_pkg::KIND_PUSH_B);
    assign is_run      = (s_data.kind == slm_pkg::KIND_RUN);
    assign lists_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);

    // Shared compare unit: strict signed less-than, B wins ties
    assign a_avail   = (ptr_a_reg < cnt_a_reg);
    assign b_avail   = (ptr_b_reg < cnt_b_reg);
    assign take_a    = a_avail && (!b_avail || (a_rdata < b_rdata));
    assign ptr_a_adv = take_a ? ptr_a_reg + ONE_C : ptr_a_reg;
    assign ptr_b_adv = take_a ? ptr_b_reg : ptr_b_reg + ONE_C;
    assign done      = (ptr_a_adv == cnt_a_reg) && (ptr_b_adv == cnt_b_reg);

    // Memory ports
    assign a_we    = in_xfer && is_push_a && (cnt_a_reg < DEPTH_C);
    assign b_we    = in_xfer && is_push_b && (cnt_b_reg < DEPTH_C);
    assign a_waddr = cnt_a_reg[ADDR_W-1:0];
    assign b_waddr = cnt_b_reg[ADDR_W-1:0];
    assign a_raddr = ptr_a_reg[ADDR_W-1:0];
    assign b_raddr = ptr_b_reg[ADDR_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slm_pkg::ST_IDLE: begin
                if (in_xfer && is_run && !lists_empty) begin
                    state_next = slm_pkg::ST_READ;
                end
            end
            slm_pkg::ST_READ: begin
                state_next = slm_pkg::ST_EMIT;
            end
            slm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = done ? slm_pkg::ST_IDLE : slm_pkg::ST_READ;
                end
            end
            default: begin
                state_next = slm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ptr_a_next     = ptr_a_reg;
        ptr_b_next     = ptr_b_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            slm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (is_push_a) begin
                        if (a_we) begin
                            cnt_a_next = cnt_a_reg + ONE_C;
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else if (is_push_b) begin
                        if (b_we) begin
                            cnt_b_next = cnt_b_reg + ONE_C;
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else if (is_run) begin
                        ptr_a_next = '0;
                        ptr_b_next = '0;
                        // empty run: nothing to emit, just clear the flag
                        if (lists_empty) begin
                            drop_next = 1'b0;
                        end
                    end
                end
            end
            slm_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next             = 1'b1;
                    out_data_next.merged_value = take_a ? a_rdata : b_rdata;
                    out_data_next.last         = done;
                    out_data_next.overflow     = drop_reg;
                    ptr_a_next                 = ptr_a_adv;
                    ptr_b_next                 = ptr_b_adv;
                    if (done) begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= slm_pkg::ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: design/sorted_list_merge_core.sv
`timescale 1ns / 1ps
// Two-way merge of sorted lists of signed 32-bit elements.
// Input channel (s_valid/s_ready/s_data): each transfer carries a kind and a
// value. Push A / push B append the value to that list; a push to a full
// list (LIST_DEPTH entries) is dropped and sets a sticky overflow flag.
// Kind code 3 is ignored. A run transfer merges both lists.
// Result channel (m_valid/m_ready/m_data): one transfer per stored element,
// ascending signed order, ties give list B first; last marks the final
// element and overflow repeats the sticky flag on every result of the run.
// After a run both lists are empty and the flag is clear; a run on empty
// lists emits nothing and only clears the flag.
// Pushes are accepted back to back. A run on non-empty lists holds s_ready
// low and handles each element as a registered memory read, then a compare
// and emit through the one shared comparator; it waits while m_ready is low.
// A finished result waits in the output register while m_ready is low; the
// merge pauses until it is taken, and pushes are taken again once the final
// result is in the output register.
// Reset (aresetn low, synchronous) empties both lists and clears the flag
// and m_valid; list contents need no clearing.

module sorted_list_merge_core #(
    parameter int unsigned LIST_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slm_pkg::slm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output slm_pkg::slm_out_t m_data
);

    localparam int unsigned ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(LIST_DEPTH + 1);

    logic                              a_we;
    logic [ADDR_W-1:0]                 a_waddr;
    logic [ADDR_W-1:0]                 a_raddr;
    logic signed [slm_pkg::ELEM_W-1:0] a_rdata;
    logic                              b_we;
    logic [ADDR_W-1:0]                 b_waddr;
    logic [ADDR_W-1:0]                 b_raddr;
    logic signed [slm_pkg::ELEM_W-1:0] b_rdata;

    // List A storage
    slm_list_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (s_data.value),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    // List B storage
    slm_list_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (s_data.value),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    // Merge sequencer with shared comparator and output register
    slm_seq #(
        .DEPTH   (LIST_DEPTH),
        .ADDR_W  (ADDR_W),
        .COUNT_W (COUNT_W)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .a_we    (a_we),
        .a_waddr (a_waddr),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .b_we    (b_we),
        .b_waddr (b_waddr),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata)
    );

`ifndef NO_ASSERTIONS
    // one item never writes both lists
    a_one_list_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(a_we && b_we))
        else $error("both list memories written in one cycle");

    // list writes only on an accepted push
    a_write_on_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_we || b_we) |-> (s_valid && s_ready))
        else $error("list write without an input transfer");

    // writes stay inside the list depth
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_we |-> (int'(a_waddr) < LIST_DEPTH)) and (b_we |-> (int'(b_waddr) < LIST_DEPTH)))
        else $error("list write address beyond depth");

    // the block only goes busy after accepting a run item
    a_busy_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && (s_data.kind == slm_pkg::KIND_RUN)))
        else $error("input stalled without a run transfer");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned LIST_DEPTH = 32;
    // Kind code with no meaning; the block takes it and drops it
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam logic signed [slm_pkg::ELEM_W-1:0] VAL_MIN =
        {1'b1, {(slm_pkg::ELEM_W-1){1'b0}}};
    localparam logic signed [slm_pkg::ELEM_W-1:0] VAL_MAX =
        {1'b0, {(slm_pkg::ELEM_W-1){1'b1}}};
    localparam longint ELEM_TOP = 64'sd2147483647;
    localparam int unsigned REPORT_LIMIT = 10;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    slm_pkg::slm_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    slm_pkg::slm_out_t m_data;

    sorted_list_merge_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of both lists, their fill levels and the sticky drop flag
    logic signed [slm_pkg::ELEM_W-1:0] shadow_a [LIST_DEPTH];
    logic signed [slm_pkg::ELEM_W-1:0] shadow_b [LIST_DEPTH];
    int unsigned       fill_a = 0;
    int unsigned       fill_b = 0;
    bit                dropped = 1'b0;
    slm_pkg::slm_out_t merge_results_q [$];

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned ignored_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned merge_runs    = 0;
    int unsigned overflow_runs = 0;
    int unsigned longest_run   = 0;
    int unsigned mismatches    = 0;

    // Update the shadow lists for one accepted item; a run queues its merged output
    function automatic void track_list_item(slm_pkg::slm_in_t item);
        int unsigned       ia;
        int unsigned       ib;
        int unsigned       total;
        bit                take_a;
        slm_pkg::slm_out_t res;
        ia = 0;
        ib = 0;
        case (item.kind)
            slm_pkg::KIND_PUSH_A: begin
                if (fill_a < LIST_DEPTH) begin
                    shadow_a[fill_a] = item.value;
                    fill_a++;
                end else begin
                    dropped = 1'b1;
                end
            end
            slm_pkg::KIND_PUSH_B: begin
                if (fill_b < LIST_DEPTH) begin
                    shadow_b[fill_b] = item.value;
                    fill_b++;
                end else begin
                    dropped = 1'b1;
                end
            end
            slm_pkg::KIND_RUN: begin
                total = fill_a + fill_b;
                for (int k = 0; k < total; k++) begin
                    // strict less-than: ties go to list B
                    if (ia < fill_a && ib < fill_b)
                        take_a = shadow_a[ia] < shadow_b[ib];
                    else
                        take_a = (ia < fill_a);
                    if (take_a) begin
                        res.merged_value = shadow_a[ia];
                        ia++;
                    end else begin
                        res.merged_value = shadow_b[ib];
                        ib++;
                    end
                    res.last     = (k + 1 == total);
                    res.overflow = dropped;
                    merge_results_q.push_back(res);
                end
                merge_runs++;
                if (dropped && total != 0)
                    overflow_runs++;
                if (total > longest_run)
                    longest_run = total;
                fill_a  = 0;
                fill_b  = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] kind,
                             input logic signed [slm_pkg::ELEM_W-1:0] value);
        slm_pkg::slm_in_t item;
        item.kind  = kind;
        item.value = value;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        track_list_item(item);
        if (kind == KIND_NOP)
            ignored_sent++;
        else
            items_sent++;
    endtask

    // Hold the input side idle until every queued result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (merge_results_q.size() != 0)
            @(posedge aclk);
    endtask

    // Check each result transfer and pick the next ready level
    always @(posedge aclk) begin : result_check
        slm_pkg::slm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (merge_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: value=%0d last=%0b overflow=%0b",
                             $realtime, m_data.merged_value, m_data.last, m_data.overflow);
            end else begin
                want = merge_results_q.pop_front();
                if (m_data.merged_value !== want.merged_value || m_data.last !== want.last
                        || m_data.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"[%0t] mismatch: value=%0d last=%0b overflow=%0b,",
                                  " expected value=%0d last=%0b overflow=%0b"},
                                 $realtime, m_data.merged_value, m_data.last,
                                 m_data.overflow, want.merged_value, want.last,
                                 want.overflow);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Next element of an ascending list, clamped at the top of the range
    function automatic longint step_up(longint prev, bit tight);
        longint nxt;
        nxt = prev + (tight ? longint'($urandom_range(2)) : longint'($urandom_range(1 << 26)));
        return (nxt > ELEM_TOP) ? ELEM_TOP : nxt;
    endfunction

    // Mostly short lists, now and then near full or past full
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6);
        else if (r < 95)
            return $urandom_range(16, 7);
        return $urandom_range(LIST_DEPTH + 2, LIST_DEPTH - 2);
    endfunction

    // Load two sorted lists in random interleave, then merge them
    task automatic merge_sequence();
        longint      cur_a;
        longint      cur_b;
        int unsigned len_a;
        int unsigned len_b;
        bit          tight;
        bit          scramble;
        len_a    = pick_len();
        len_b    = pick_len();
        tight    = ($urandom_range(3) == 0);
        scramble = ($urandom_range(9) == 0);
        // narrow value band makes ties common
        if (tight) begin
            cur_a = longint'($urandom_range(20)) - 10;
            cur_b = longint'($urandom_range(20)) - 10;
        end else begin
            cur_a = longint'($signed($urandom()));
            cur_b = longint'($signed($urandom()));
        end
        while (len_a + len_b > 0) begin
            if ($urandom_range(19) == 0)
                send_item(KIND_NOP, $urandom());
            if (len_a > 0 && (len_b == 0 || $urandom_range(1) == 1)) begin
                send_item(slm_pkg::KIND_PUSH_A, cur_a[slm_pkg::ELEM_W-1:0]);
                cur_a = scramble ? longint'($signed($urandom())) : step_up(cur_a, tight);
                len_a--;
            end else begin
                send_item(slm_pkg::KIND_PUSH_B, cur_b[slm_pkg::ELEM_W-1:0]);
                cur_b = scramble ? longint'($signed($urandom())) : step_up(cur_b, tight);
                len_b--;
            end
        end
        // now and then the lists carry over into the next sequence
        if ($urandom_range(9) != 0)
            send_item(slm_pkg::KIND_RUN, $urandom());
    endtask

    // Range extremes, ties, empty and one-sided merges, ignored kind, unsorted lists
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(slm_pkg::KIND_RUN, 0);
        send_item(KIND_NOP, VAL_MAX);
        send_item(KIND_NOP, VAL_MIN);
        send_item(slm_pkg::KIND_PUSH_A, VAL_MIN);
        send_item(slm_pkg::KIND_PUSH_B, VAL_MIN);
        send_item(slm_pkg::KIND_PUSH_A, -1);
        send_item(slm_pkg::KIND_PUSH_B, -1);
        send_item(slm_pkg::KIND_PUSH_A, 0);
        send_item(slm_pkg::KIND_PUSH_B, 1);
        send_item(slm_pkg::KIND_PUSH_A, VAL_MAX);
        send_item(slm_pkg::KIND_PUSH_B, VAL_MAX);
        send_item(slm_pkg::KIND_RUN, -1);
        send_item(slm_pkg::KIND_PUSH_A, 5);
        send_item(slm_pkg::KIND_PUSH_A, 7);
        send_item(slm_pkg::KIND_RUN, 0);
        send_item(slm_pkg::KIND_PUSH_B, -3);
        send_item(slm_pkg::KIND_RUN, 0);
        send_item(slm_pkg::KIND_PUSH_A, 10);
        send_item(slm_pkg::KIND_PUSH_A, 2);
        send_item(slm_pkg::KIND_PUSH_B, 5);
        send_item(slm_pkg::KIND_RUN, 0);
        wait_drained();
    endtask

    // Both lists full with drops, then a small run that must show the flag cleared
    task automatic test_full_lists();
        longint cur;
        idle_pct  = 25;
        stall_pct = 25;
        cur = longint'($signed($urandom()));
        for (int i = 0; i <= LIST_DEPTH; i++) begin
            send_item(slm_pkg::KIND_PUSH_A, cur[slm_pkg::ELEM_W-1:0]);
            send_item(slm_pkg::KIND_PUSH_B, $urandom());
            cur = step_up(cur, 1'b0);
        end
        send_item(slm_pkg::KIND_RUN, 0);
        send_item(slm_pkg::KIND_PUSH_B, VAL_MIN);
        send_item(slm_pkg::KIND_RUN, 0);
        wait_drained();
    endtask

    // Random sequences under each idling mix, draining between mixes
    task automatic test_random_phases();
        int unsigned phase_idle  [4] = '{0, 49, 0, 25};
        int unsigned phase_stall [4] = '{0, 0, 49, 25};
        int unsigned mark;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            mark      = items_sent;
            while (items_sent - mark < 12)
                merge_sequence();
            wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_lists();
        test_random_phases();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d list items and %0d ignored items; %0d merge runs, %0d with overflow.",
                 items_sent, ignored_sent, merge_runs, overflow_runs);
        $display("Checked %0d merged elements, longest run %0d, %0d mismatches.",
                 results_seen, longest_run, mismatches);
        if (mismatches == 0 && merge_results_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", merge_results_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sorted_list_merge_core.f
design/slm_pkg.sv
design/slm_list_mem.sv
design/slm_seq.sv
design/sorted_list_merge_core.sv
tb/sv/tb.sv
